[rtl/core/swpc_pkg.sv]
// Shared types, constants and CRC-8 function of the sensor word pair CRC checker.
package swpc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TEMP_BAD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HUM_BAD  = 2'd2;

   typedef enum logic [2:0] {
      POS_T_HI  = 3'd0,
      POS_T_LO  = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_HI  = 3'd3,
      POS_H_LO  = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   typedef struct packed {
      logic                valid;
      logic [WORD_W-1:0]   temperature_raw;
      logic [WORD_W-1:0]   humidity_raw;
      logic [STATUS_W-1:0] check_status;
   } result_type;

   function automatic logic [BYTE_W-1:0] crc8_byte(
      input logic [BYTE_W-1:0] crc,
      input logic [BYTE_W-1:0] data
   );
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_TOP) != '0) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/core/swpc_parser.sv]
// Byte position tracking, running CRC-8 and word assembly of the sensor reply.
module swpc_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [swpc_pkg::BYTE_W-1:0] rx_byte,
   input  logic                        frame_start,
   output swpc_pkg::result_type        result
);

   swpc_pkg::pos_type pos_ff, pos_in, pos_cur;
   logic [swpc_pkg::BYTE_W-1:0] crc_ff, crc_in, crc_base, crc_next;
   logic [swpc_pkg::WORD_W-1:0] temp_word_ff, temp_word_in;
   logic [swpc_pkg::BYTE_W-1:0] hum_hi_ff, hum_hi_in;
   logic [swpc_pkg::BYTE_W-1:0] hum_lo_ff, hum_lo_in;
   logic temp_ok_ff, temp_ok_in;

   assign pos_cur  = frame_start ? swpc_pkg::POS_T_HI : pos_ff;
   assign crc_base = (pos_cur == swpc_pkg::POS_T_LO || pos_cur == swpc_pkg::POS_H_LO)
                     ? crc_ff : swpc_pkg::CRC_INIT;
   assign crc_next = swpc_pkg::crc8_byte(crc_base, rx_byte);

   // next position
   always_comb begin
      pos_in = pos_ff;
      if (step) begin
         unique case (pos_cur)
            swpc_pkg::POS_T_HI:  pos_in = swpc_pkg::POS_T_LO;
            swpc_pkg::POS_T_LO:  pos_in = swpc_pkg::POS_T_CRC;
            swpc_pkg::POS_T_CRC: pos_in = swpc_pkg::POS_H_HI;
            swpc_pkg::POS_H_HI:  pos_in = swpc_pkg::POS_H_LO;
            swpc_pkg::POS_H_LO:  pos_in = swpc_pkg::POS_H_CRC;
            swpc_pkg::POS_H_CRC: pos_in = swpc_pkg::POS_T_HI;
            default:             pos_in = swpc_pkg::POS_T_LO;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_hi_in    = hum_hi_ff;
      hum_lo_in    = hum_lo_ff;
      temp_ok_in   = temp_ok_ff;
      result.valid           = (pos_cur == swpc_pkg::POS_H_CRC);
      result.temperature_raw = temp_word_ff;
      result.humidity_raw    = {hum_hi_ff, hum_lo_ff};
      if (!temp_ok_ff) begin
         result.check_status = swpc_pkg::STATUS_TEMP_BAD;
      end else if (crc_ff != rx_byte) begin
         result.check_status = swpc_pkg::STATUS_HUM_BAD;
      end else begin
         result.check_status = swpc_pkg::STATUS_OK;
      end
      if (step) begin
         unique case (pos_cur)
            swpc_pkg::POS_T_HI: begin
               crc_in       = crc_next;
               temp_word_in = {rx_byte, 8'h00};
            end
            swpc_pkg::POS_T_LO: begin
               crc_in       = crc_next;
               temp_word_in = {temp_word_ff[15:8], rx_byte};
            end
            swpc_pkg::POS_T_CRC: begin
               temp_ok_in = (crc_ff == rx_byte);
               crc_in     = swpc_pkg::CRC_INIT;
            end
            swpc_pkg::POS_H_HI: begin
               crc_in    = crc_next;
               hum_hi_in = rx_byte;
            end
            swpc_pkg::POS_H_LO: begin
               crc_in    = crc_next;
               hum_lo_in = rx_byte;
            end
            swpc_pkg::POS_H_CRC: begin
               crc_in = swpc_pkg::CRC_INIT;
            end
            default: begin
               crc_in       = crc_next;
               temp_word_in = {rx_byte, 8'h00};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= swpc_pkg::POS_T_HI;
         crc_ff       <= swpc_pkg::CRC_INIT;
         temp_word_ff <= '0;
         hum_hi_ff    <= '0;
         hum_lo_ff    <= '0;
         temp_ok_ff   <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_hi_ff    <= hum_hi_in;
         hum_lo_ff    <= hum_lo_in;
         temp_ok_ff   <= temp_ok_in;
      end
   end

   a_wrap_after_result: assert property (@(posedge clock) disable iff (reset)
      (step && result.valid) |=> (pos_ff == swpc_pkg::POS_T_HI && crc_ff == swpc_pkg::CRC_INIT))
      else $error("position or CRC not restarted after a result");

   a_start_resync: assert property (@(posedge clock) disable iff (reset)
      (step && frame_start) |=> (pos_ff == swpc_pkg::POS_T_LO))
      else $error("frame start did not resync the byte position");

   a_temp_bad_flag: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.check_status == swpc_pkg::STATUS_TEMP_BAD) |-> !temp_ok_ff)
      else $error("temperature mismatch reported with a good temperature CRC");

endmodule

[rtl/core/sensor_word_pair_crc_checker_unit.sv]
// Top level of the sensor word pair CRC checker: stream ports, input and result registers.
//
// Usage: feed the six bytes of a sensor measurement reply on the req_ stream,
// one byte per transfer: temperature high, low, CRC, humidity high, low, CRC.
// req_tuser[0] marks the first byte of a reply and resyncs the byte position;
// a partly received reply is then dropped. Each word is checked with CRC-8
// (poly 0x31, init 0xFF). On the sixth byte one transfer leaves on rsp_:
// both raw words and a status (0 ok, 1 temperature mismatch, 2 humidity
// mismatch; temperature wins when both fail). Other bytes give no transfer.
// A result reaches rsp_tvalid through the input register, then the result
// register. The unit takes one byte per cycle while not stalled, as the
// CRC-8 byte step between the two registers is combinational.
// Reset (synchronous, active high) empties both registers and restarts the
// byte position at the first byte. When the receiver stalls, the result is
// held and the input register keeps accepting bytes that give no result;
// req_tready drops only when a new result would have to pass a held one.
module sensor_word_pair_crc_checker_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swpc_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] rx_byte
   input  logic [0:0]                      req_tuser,  // [0] frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] temperature_raw, [31:16] humidity_raw, [33:32] check_status, [39:34] zero
   output logic [swpc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic in_valid_ff, in_valid_in;
   logic [swpc_pkg::BYTE_W-1:0] in_byte_ff;
   logic in_start_ff;
   logic out_valid_ff, out_valid_in;
   logic [swpc_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic stall, step;
   swpc_pkg::result_type result;

   // hold the input byte only when its result would overwrite a waiting one
   assign stall       = in_valid_ff && (in_start_ff ? 1'b0 : 1'b1) && out_valid_ff
                        && !rsp_tready && result.valid;
   assign step        = in_valid_ff && !stall;
   assign req_tready  = !in_valid_ff || !stall;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (step && result.valid) begin
         out_valid_in = 1'b1;
      end
   end

   swpc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata[swpc_pkg::BYTE_W-1:0];
         in_start_ff <= req_tuser[0];
      end
      if (step && result.valid) begin
         out_data_ff <= {6'b0, result.check_status, result.humidity_raw,
                         result.temperature_raw};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[tb/swpc_reply_checker.sv]
// Reply checker for the sensor word pair CRC checker: CRC helpers, byte decoder and result compare.
`timescale 1ns / 100ps

package swpc_tb_pkg;

   import swpc_pkg::*;

   function automatic logic [BYTE_W-1:0] crc8_shift(
      input logic [BYTE_W-1:0] crc,
      input logic [BYTE_W-1:0] data
   );
      logic [BYTE_W-1:0] c;
      logic              fb;
      c = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = c[BYTE_W-1] ^ data[i];
         c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] crc8_word(input logic [WORD_W-1:0] w);
      return crc8_shift(crc8_shift(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

endpackage

module swpc_reply_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [swpc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [swpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              replies_pending,
   output int                              replies_checked
);

   import swpc_pkg::*;
   import swpc_tb_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0]   temperature_raw;
      logic [WORD_W-1:0]   humidity_raw;
      logic [STATUS_W-1:0] check_status;
   } reply_type;

   reply_type         reply_queue[$];
   pos_type           next_pos;
   logic [BYTE_W-1:0] word_crc;
   logic [WORD_W-1:0] temp_word;
   logic [BYTE_W-1:0] hum_hi;
   logic [BYTE_W-1:0] hum_lo;
   logic              temp_ok;

   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic start);
      pos_type   pos;
      reply_type r;
      if (start) begin
         next_pos = POS_T_HI;
         word_crc = CRC_INIT;
      end
      pos = next_pos;
      case (pos)
         POS_T_HI: begin
            word_crc  = crc8_shift(CRC_INIT, b);
            temp_word = {b, 8'h00};
            next_pos  = POS_T_LO;
         end
         POS_T_LO: begin
            word_crc       = crc8_shift(word_crc, b);
            temp_word[7:0] = b;
            next_pos       = POS_T_CRC;
         end
         POS_T_CRC: begin
            temp_ok  = (word_crc == b);
            word_crc = CRC_INIT;
            next_pos = POS_H_HI;
         end
         POS_H_HI: begin
            word_crc = crc8_shift(CRC_INIT, b);
            hum_hi   = b;
            next_pos = POS_H_LO;
         end
         POS_H_LO: begin
            word_crc = crc8_shift(word_crc, b);
            hum_lo   = b;
            next_pos = POS_H_CRC;
         end
         default: begin
            r.temperature_raw = temp_word;
            r.humidity_raw    = {hum_hi, hum_lo};
            if (!temp_ok) begin
               r.check_status = STATUS_TEMP_BAD;
            end else if (word_crc != b) begin
               r.check_status = STATUS_HUM_BAD;
            end else begin
               r.check_status = STATUS_OK;
            end
            reply_queue.push_back(r);
            next_pos = POS_T_HI;
            word_crc = CRC_INIT;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         reply_queue.delete();
         next_pos  = POS_T_HI;
         word_crc  = CRC_INIT;
         temp_word = '0;
         hum_hi    = '0;
         hum_lo    = '0;
         temp_ok   = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               $error("result transfer with nothing expected: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = reply_queue.pop_front();
               check_field("temperature_raw", want.temperature_raw, rsp_tdata[15:0]);
               check_field("humidity_raw", want.humidity_raw, rsp_tdata[31:16]);
               check_field("check_status", WORD_W'(want.check_status), WORD_W'(rsp_tdata[33:32]));
               check_field("tdata padding", '0, WORD_W'(rsp_tdata[39:34]));
               replies_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata[7:0], req_tuser[0]);
         end
      end
      replies_pending = reply_queue.size();
   end

endmodule

[tb/sensor_word_pair_crc_checker_unit_tb.sv]
// Top of the sensor word pair CRC checker testbench: clock, reset, reply stimulus and verdict.
`timescale 1ns / 100ps

module sensor_word_pair_crc_checker_unit_tb;

   import swpc_pkg::*;
   import swpc_tb_pkg::*;

   localparam int RUN_LIMIT       = 200000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_BYTES     = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [7:0] rx_byte
   logic [0:0]            req_tuser;   // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [15:0] temperature_raw, [31:16] humidity_raw, [33:32] check_status, [39:34] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int   fail_count;
   int   replies_pending;
   int   replies_checked;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   hold_left      = 0;
   int   bytes_sent     = 0;
   int   cycle_count    = 0;
   logic req_fire       = 1'b0;

   int   phase_idle[4]  = '{0, 59, 0, 25};
   int   phase_stall[4] = '{0, 0, 59, 25};

   sensor_word_pair_crc_checker_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   swpc_reply_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .replies_pending (replies_pending),
      .replies_checked (replies_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      req_fire    <= !reset && req_tvalid && req_tready;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: held off while hold_left counts down, random stalls otherwise
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(negedge clock); while (!req_fire);
      bytes_sent++;
   endtask

   // corrupt[0] spoils the temperature CRC, corrupt[1] the humidity CRC
   task automatic send_reply(input logic [WORD_W-1:0] t, input logic [WORD_W-1:0] h,
                             input logic [1:0] corrupt, input logic start);
      logic [BYTE_W-1:0] t_crc;
      logic [BYTE_W-1:0] h_crc;
      t_crc = crc8_word(t) ^ (corrupt[0] ? 8'($urandom_range(255, 1)) : 8'h00);
      h_crc = crc8_word(h) ^ (corrupt[1] ? 8'($urandom_range(255, 1)) : 8'h00);
      send_byte(t[15:8], start);
      send_byte(t[7:0], 1'b0);
      send_byte(t_crc, 1'b0);
      send_byte(h[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(h_crc, 1'b0);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (replies_pending != 0);
   endtask

   task automatic run_random(input int n_bytes);
      int target;
      int kind;
      int len;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         kind = $urandom_range(99);
         if (kind < 87) begin
            send_reply(rand_word(), rand_word(),
                       ($urandom_range(9) < 3) ? 2'($urandom_range(3, 1)) : 2'b00,
                       kind < 75);
         end else begin
            len = $urandom_range(5, 1);
            repeat (len) send_byte(8'($urandom), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // dropped partial reply, then all status codes, extremes and a wrap without frame start
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h3C, 1'b0);
      send_reply(16'h0000, 16'h0000, 2'b00, 1'b1);
      send_reply(16'hFFFF, 16'hFFFF, 2'b01, 1'b1);
      send_reply(16'hBEEF, 16'hFFFF, 2'b10, 1'b1);
      send_reply(16'h8000, 16'h0001, 2'b11, 1'b0);
      drain_replies();

      // hold the receiver off while the sender keeps offering full replies
      hold_left = HOLD_OFF_CYCLES;
      repeat (12) send_reply(rand_word(), rand_word(), 2'($urandom_range(3)), 1'b1);
      drain_replies();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         run_random(PHASE_BYTES);
         drain_replies();
      end

      repeat (10) @(negedge clock);
      $display("Run sent %0d reply bytes: directed replies, a long receiver hold-off", bytes_sent);
      $display("and four idle/stall mixes; %0d results compared.", replies_checked);
      if (fail_count == 0 && replies_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
